[sv/bqf_pkg.sv]
`default_nettype none

package bqf_pkg;

    // fixed field widths
    localparam int COEF_BITS          = 20;
    localparam int SUM_BITS           = 40;
    localparam int DEF_SAMPLE_BITS    = 16;
    localparam int DEF_COEF_FRAC_BITS = 16;

    // apb register map, one register every four bytes
    localparam int ADDR_BITS = 5;
    localparam int IDX_BITS  = 3;

    localparam logic [IDX_BITS-1:0] REG_B0     = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_B1     = 3'd1;
    localparam logic [IDX_BITS-1:0] REG_B2     = 3'd2;
    localparam logic [IDX_BITS-1:0] REG_A1     = 3'd3;
    localparam logic [IDX_BITS-1:0] REG_A2     = 3'd4;
    localparam logic [IDX_BITS-1:0] REG_BYPASS = 3'd5;

    // microprogram step counter
    localparam int STEP_BITS = 4;

    localparam logic [STEP_BITS-1:0] STEP_BYPASS = 4'd8;

    // coefficient and operand pair fed to the shared multiplier
    typedef enum logic [2:0] {
        MS_B0X = 3'd0,
        MS_B1X = 3'd1,
        MS_B2X = 3'd2,
        MS_A1Y = 3'd3,
        MS_A2Y = 3'd4
    } mul_sel_t;

    // accumulator operation
    typedef enum logic [2:0] {
        AO_HOLD     = 3'd0,
        AO_LOAD_S1H = 3'd1,
        AO_ADD      = 3'd2,
        AO_LOAD_S2P = 3'd3,
        AO_SUB      = 3'd4,
        AO_LOAD_P   = 3'd5
    } acc_op_t;

    // jump condition
    typedef enum logic [0:0] {
        JC_NONE   = 1'b0,
        JC_BYPASS = 1'b1
    } jcond_t;

    // one control word of the microprogram
    typedef struct packed {
        mul_sel_t             mul_sel;
        acc_op_t              acc_op;
        logic                 y_wr;
        logic                 s1_wr;
        logic                 s2_wr;
        logic                 byp_out;
        logic                 done;
        jcond_t               jcond;
        logic [STEP_BITS-1:0] jtarget;
    } ctrl_t;

    localparam ctrl_t CTRL_NOP = '{
        mul_sel: MS_B0X, acc_op: AO_HOLD, y_wr: 1'b0, s1_wr: 1'b0, s2_wr: 1'b0,
        byp_out: 1'b0, done: 1'b0, jcond: JC_NONE, jtarget: '0
    };

    // microprogram rom
    function automatic ctrl_t ucode(input logic [STEP_BITS-1:0] step);
        ctrl_t w;
        w = CTRL_NOP;
        case (step)
            4'd0:
            begin
                w.mul_sel = MS_B0X;
                w.acc_op  = AO_LOAD_S1H;
                w.jcond   = JC_BYPASS;
                w.jtarget = STEP_BYPASS;
            end
            4'd1:
            begin
                w.mul_sel = MS_B1X;
                w.acc_op  = AO_ADD;
            end
            4'd2:
            begin
                w.mul_sel = MS_B1X;
                w.acc_op  = AO_LOAD_S2P;
                w.y_wr    = 1'b1;
            end
            4'd3:
            begin
                w.mul_sel = MS_A1Y;
                w.acc_op  = AO_HOLD;
            end
            4'd4:
            begin
                w.mul_sel = MS_B2X;
                w.acc_op  = AO_SUB;
            end
            4'd5:
            begin
                w.mul_sel = MS_A2Y;
                w.acc_op  = AO_LOAD_P;
                w.s1_wr   = 1'b1;
            end
            4'd6:
            begin
                w.acc_op  = AO_SUB;
            end
            4'd7:
            begin
                w.s2_wr   = 1'b1;
                w.done    = 1'b1;
            end
            STEP_BYPASS:
            begin
                w.byp_out = 1'b1;
                w.done    = 1'b1;
            end
            default:
            begin
                w.done    = 1'b1;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

[sv/bqf_seq.sv]
`default_nettype none

module bqf_seq
    import bqf_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  start,
    input  wire logic  bypass,
    input  wire logic  out_free,
    output ctrl_t      ctrl,
    output logic       idle
);

    typedef enum logic [1:0] {
        SQ_IDLE = 2'b01,
        SQ_RUN  = 2'b10
    } seq_state_t;

    seq_state_t           state_reg, state_next;
    logic [STEP_BITS-1:0] step_reg, step_next;
    ctrl_t                word;

    // rom lookup
    assign word = ucode(step_reg);
    assign idle = (state_reg == SQ_IDLE);
    assign ctrl = (state_reg == SQ_RUN) ? word : CTRL_NOP;

    // step counter with conditional jump, stalls on the final word until output frees
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            SQ_IDLE:
            begin
                if (start)
                begin
                    state_next = SQ_RUN;
                    step_next  = '0;
                end
            end
            SQ_RUN:
            begin
                if (word.done)
                begin
                    if (out_free)
                    begin
                        state_next = SQ_IDLE;
                    end
                end
                else if (word.jcond == JC_BYPASS && bypass)
                begin
                    step_next = word.jtarget;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = SQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SQ_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

`default_nettype wire

[sv/biquad_iir_filter.sv]
`default_nettype none

// channel   | dir | signals                         | contents
// s_axis    | in  | s_tvalid s_tready s_tdata s_tuser | sample_in, clear_state
// m_axis    | out | m_tvalid m_tready m_tdata m_tuser | sample_out, saturated
// apb       | in  | psel penable pwrite paddr pwdata  | b0 b1 b2 a1 a2 bypass
//
// a filtered sample's five products share one registered multiplier and
// one accumulator, stepped by the microprogram; a bypassed sample skips them.
// s_tready is high only while the sequencer is idle; a finished result waits in
// the output register, and the sequencer holds its last step until it is free.
// reset clears both partial sums, sets b0 to unity and all other configuration registers to zero.

module biquad_iir_filter
    import bqf_pkg::*;
#(
    parameter int SAMPLE_BITS    = DEF_SAMPLE_BITS,
    parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS,
    localparam int TDATA_BITS    = ((SAMPLE_BITS + 7) / 8) * 8
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // input stream
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [TDATA_BITS-1:0]  s_tdata,   // sample_in
    input  wire logic                   s_tuser,   // clear_state
    // output stream
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [TDATA_BITS-1:0]       m_tdata,   // sample_out
    output logic                        m_tuser,   // saturated
    // configuration
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [ADDR_BITS-1:0]   paddr,
    input  wire logic [31:0]            pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int PROD_BITS  = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_BITS   = ((SUM_BITS > PROD_BITS) ? SUM_BITS : PROD_BITS) + 2;

    localparam logic signed [COEF_BITS-1:0] B0_RESET =
        (COEF_FRAC_BITS < COEF_BITS - 1) ? COEF_BITS'(longint'(1) << COEF_FRAC_BITS)
                                         : {1'b0, {(COEF_BITS-1){1'b1}}};
    localparam logic signed [ACC_BITS-1:0] ROUND_HALF =
        ACC_BITS'(longint'(1) << (COEF_FRAC_BITS - 1));

    // configuration registers
    logic signed [COEF_BITS-1:0] b0_reg, b1_reg, b2_reg, a1_reg, a2_reg;
    logic                        bypass_reg;
    logic                        cfg_wr;
    logic [IDX_BITS-1:0]         cfg_idx;

    // datapath
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic signed [SAMPLE_BITS-1:0] y_reg;
    logic                          sat_reg;
    logic signed [SUM_BITS-1:0]    s1_reg, s2_reg;
    logic signed [PROD_BITS-1:0]   prod_reg;
    logic signed [ACC_BITS-1:0]    acc_reg, acc_next;
    logic signed [SAMPLE_BITS-1:0] mul_a;
    logic signed [COEF_BITS-1:0]   mul_b;
    logic signed [ACC_BITS-1:0]    acc_shr;
    logic [ACC_BITS-SAMPLE_BITS:0] y_hi;
    logic                          y_fits;
    logic signed [SAMPLE_BITS-1:0] y_next;
    logic [ACC_BITS-SUM_BITS:0]    s_hi;
    logic signed [SUM_BITS-1:0]    s_sat;

    // output register
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] out_data_reg;
    logic                          out_sat_reg;
    logic                          out_free;
    logic                          in_req;
    logic                          seq_idle;
    ctrl_t                         ctrl;

    // apb decode
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = paddr[ADDR_BITS-1:2];

    always_comb
    begin
        prdata = '0;
        unique case (cfg_idx)
            REG_B0:     prdata = 32'($unsigned(b0_reg));
            REG_B1:     prdata = 32'($unsigned(b1_reg));
            REG_B2:     prdata = 32'($unsigned(b2_reg));
            REG_A1:     prdata = 32'($unsigned(a1_reg));
            REG_A2:     prdata = 32'($unsigned(a2_reg));
            REG_BYPASS: prdata = 32'(bypass_reg);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_reg     <= B0_RESET;
            b1_reg     <= '0;
            b2_reg     <= '0;
            a1_reg     <= '0;
            a2_reg     <= '0;
            bypass_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_B0:     b0_reg     <= pwdata[COEF_BITS-1:0];
                REG_B1:     b1_reg     <= pwdata[COEF_BITS-1:0];
                REG_B2:     b2_reg     <= pwdata[COEF_BITS-1:0];
                REG_A1:     a1_reg     <= pwdata[COEF_BITS-1:0];
                REG_A2:     a2_reg     <= pwdata[COEF_BITS-1:0];
                REG_BYPASS: bypass_reg <= pwdata[0];
                default:    ;
            endcase
        end
    end

    // handshakes
    assign s_tready = seq_idle;
    assign in_req   = s_tvalid & s_tready;
    assign out_free = !out_valid_reg || m_tready;

    bqf_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_req),
        .bypass   (bypass_reg),
        .out_free (out_free),
        .ctrl     (ctrl),
        .idle     (seq_idle)
    );

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a = x_reg;
        mul_b = b0_reg;
        case (ctrl.mul_sel)
            MS_B0X:
            begin
                mul_a = x_reg;
                mul_b = b0_reg;
            end
            MS_B1X:
            begin
                mul_a = x_reg;
                mul_b = b1_reg;
            end
            MS_B2X:
            begin
                mul_a = x_reg;
                mul_b = b2_reg;
            end
            MS_A1Y:
            begin
                mul_a = y_reg;
                mul_b = a1_reg;
            end
            MS_A2Y:
            begin
                mul_a = y_reg;
                mul_b = a2_reg;
            end
            default:
            begin
                mul_a = x_reg;
                mul_b = b0_reg;
            end
        endcase
    end

    // accumulator
    always_comb
    begin
        acc_next = acc_reg;
        case (ctrl.acc_op)
            AO_LOAD_S1H: acc_next = ACC_BITS'(s1_reg) + ROUND_HALF;
            AO_ADD:      acc_next = acc_reg + ACC_BITS'(prod_reg);
            AO_LOAD_S2P: acc_next = ACC_BITS'(s2_reg) + ACC_BITS'(prod_reg);
            AO_SUB:      acc_next = acc_reg - ACC_BITS'(prod_reg);
            AO_LOAD_P:   acc_next = ACC_BITS'(prod_reg);
            default:     acc_next = acc_reg;
        endcase
    end

    // round half up and clamp to the sample range
    assign acc_shr = acc_reg >>> COEF_FRAC_BITS;
    assign y_hi    = acc_shr[ACC_BITS-1:SAMPLE_BITS-1];
    assign y_fits  = (&y_hi) || !(|y_hi);
    assign y_next  = y_fits ? acc_shr[SAMPLE_BITS-1:0]
                            : {acc_shr[ACC_BITS-1], {(SAMPLE_BITS-1){~acc_shr[ACC_BITS-1]}}};

    // clamp a new partial sum to its width
    assign s_hi  = acc_reg[ACC_BITS-1:SUM_BITS-1];
    assign s_sat = ((&s_hi) || !(|s_hi))
                 ? acc_reg[SUM_BITS-1:0]
                 : {acc_reg[ACC_BITS-1], {(SUM_BITS-1){~acc_reg[ACC_BITS-1]}}};

    // datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        acc_reg  <= acc_next;
        if (in_req)
        begin
            x_reg <= s_tdata[SAMPLE_BITS-1:0];
        end
        if (ctrl.y_wr)
        begin
            y_reg   <= y_next;
            sat_reg <= !y_fits;
        end
    end

    // partial sums, cleared at reset and by a request that asks for it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
            s2_reg <= '0;
        end
        else if (in_req && s_tuser)
        begin
            s1_reg <= '0;
            s2_reg <= '0;
        end
        else
        begin
            if (ctrl.s1_wr)
            begin
                s1_reg <= s_sat;
            end
            if (ctrl.s2_wr)
            begin
                s2_reg <= s_sat;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.done && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.done && out_free)
        begin
            out_data_reg <= ctrl.byp_out ? x_reg : y_reg;
            out_sat_reg  <= ctrl.byp_out ? 1'b0 : sat_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_BITS'($unsigned(out_data_reg));
    assign m_tuser  = out_sat_reg;

    // a full output register that is not drained holds the sequencer on its last step
    a_done_stall: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.done && out_valid_reg && !m_tready |=> ctrl.done)
        else $error("sequencer left its final step while output was blocked");

    // a request starts the program, so no second request next cycle
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        in_req |=> !s_tready)
        else $error("input ready right after a request");

    // the first partial sum (step 5) is written after the output sample (step 2)
    a_s1_after_y: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.s1_wr |-> $past(ctrl.y_wr, 3))
        else $error("partial sum written out of program order");

    // a result appears only from a final program step
    a_valid_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(ctrl.done))
        else $error("output valid without a finished program");

endmodule

`default_nettype wire

[bench/tb_biquad_iir_filter.sv]
module tb_biquad_iir_filter;

    import bqf_pkg::*;

    localparam int SBITS   = DEF_SAMPLE_BITS;
    localparam int FRAC    = DEF_COEF_FRAC_BITS;
    localparam int SMAX    = (1 << (SBITS - 1)) - 1;
    localparam int SMIN    = -SMAX - 1;
    localparam int CMAX    = (1 << (COEF_BITS - 1)) - 1;
    localparam int CMIN    = -CMAX - 1;
    localparam longint SUM_MAX = (64'sd1 <<< (SUM_BITS - 1)) - 1;
    localparam longint SUM_MIN = -SUM_MAX - 1;
    localparam int PHASES  = 12;

    // addresses past the register map, writes there must be ignored
    localparam logic [IDX_BITS-1:0] REG_SPARE6 = 3'd6;
    localparam logic [IDX_BITS-1:0] REG_SPARE7 = 3'd7;

    typedef enum {ROW_CFG, ROW_SAMPLE} row_kind_t;

    typedef struct packed {
        logic signed [SBITS-1:0] y;
        logic                    sat;
    } filt_res_t;

    // directed row: register write or one sample, optionally with a known answer
    typedef struct {
        row_kind_t             kind;
        logic [IDX_BITS-1:0]   idx;
        int                    value;
        logic                  clr;
        bit                    typed;
        int                    exp_y;
        bit                    exp_sat;
    } dir_row_t;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [SBITS-1:0]      s_tdata  = '0;    // sample_in
    logic                  s_tuser  = 1'b0;  // clear_state
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [SBITS-1:0]      m_tdata;          // sample_out
    logic                  m_tuser;          // saturated
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [ADDR_BITS-1:0]  paddr    = '0;
    logic [31:0]           pwdata   = '0;
    logic [31:0]           prdata;
    logic                  pready;

    // travels alongside each request: a typed answer replaces the prediction
    bit                    row_typed  = 1'b0;
    filt_res_t             row_expect = '0;

    // filter state and coefficients as the bench sees them
    logic signed [COEF_BITS-1:0] k_b0, k_b1, k_b2, k_a1, k_a2;
    logic                        k_bypass;
    longint                      sum_first, sum_second;

    filt_res_t             expected_samples[$];
    filt_res_t             want, got;
    int                    samples_sent    = 0;
    int                    samples_checked = 0;
    int                    mismatch_cnt    = 0;
    int                    clipped_cnt     = 0;
    int                    bypassed_cnt    = 0;
    int                    reg_writes      = 0;
    int                    burst_left      = 0;
    int                    tx_mode         = 0;
    int                    rx_mode         = 0;
    int                    rx_hold         = 0;
    dir_row_t              dir_rows[$];

    biquad_iir_filter #(
        .SAMPLE_BITS    (SBITS),
        .COEF_FRAC_BITS (FRAC)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #1 clk = ~clk;

    // clamp a partial sum to the 40-bit range
    function automatic longint clamp_sum(input longint v);
        if (v > SUM_MAX)
            return SUM_MAX;
        if (v < SUM_MIN)
            return SUM_MIN;
        return v;
    endfunction

    // one filter step, advances the bench copy of the partial sums
    function automatic filt_res_t biquad_predict(input logic signed [SBITS-1:0] x,
                                                 input logic clr);
        filt_res_t r;
        longint    acc;
        longint    yv;
        if (clr)
        begin
            sum_first  = 0;
            sum_second = 0;
        end
        if (k_bypass)
        begin
            bypassed_cnt++;
            r.y   = x;
            r.sat = 1'b0;
            return r;
        end
        acc = longint'(k_b0) * longint'(x) + sum_first + (64'sd1 <<< (FRAC - 1));
        yv  = acc >>> FRAC;
        r.sat = 1'b0;
        if (yv > SMAX)
        begin
            yv    = SMAX;
            r.sat = 1'b1;
        end
        else if (yv < SMIN)
        begin
            yv    = SMIN;
            r.sat = 1'b1;
        end
        if (r.sat)
            clipped_cnt++;
        sum_first  = clamp_sum(longint'(k_b1) * longint'(x) - longint'(k_a1) * yv
                               + sum_second);
        sum_second = clamp_sum(longint'(k_b2) * longint'(x) - longint'(k_a2) * yv);
        r.y = yv[SBITS-1:0];
        return r;
    endfunction

    task automatic note_mismatch(input string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("ERROR: %s", msg);
    endtask

    // track register writes, predict on each input request, check each result
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_b0       = (FRAC < COEF_BITS - 1) ? COEF_BITS'(1 << FRAC) : COEF_BITS'(CMAX);
            k_b1       = '0;
            k_b2       = '0;
            k_a1       = '0;
            k_a2       = '0;
            k_bypass   = 1'b0;
            sum_first  = 0;
            sum_second = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[ADDR_BITS-1:2])
                    REG_B0:     k_b0 = pwdata[COEF_BITS-1:0];
                    REG_B1:     k_b1 = pwdata[COEF_BITS-1:0];
                    REG_B2:     k_b2 = pwdata[COEF_BITS-1:0];
                    REG_A1:     k_a1 = pwdata[COEF_BITS-1:0];
                    REG_A2:     k_a2 = pwdata[COEF_BITS-1:0];
                    REG_BYPASS: k_bypass = pwdata[0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_samples.size() == 0)
                    note_mismatch($sformatf("result %0d arrived with none pending: %0d sat %0b",
                                            samples_checked, $signed(m_tdata), m_tuser));
                else
                begin
                    want = expected_samples.pop_front();
                    if (m_tdata !== want.y || m_tuser !== want.sat)
                        note_mismatch($sformatf("result %0d: exp %0d sat %0b, got %0d sat %0b",
                                                samples_checked, want.y, want.sat,
                                                $signed(m_tdata), m_tuser));
                end
                samples_checked <= samples_checked + 1;
            end
            if (s_tvalid && s_tready)
            begin
                got = biquad_predict($signed(s_tdata), s_tuser);
                if (row_typed)
                    got = row_expect;
                expected_samples.push_back(got);
            end
        end
    end

    // receiver: always ready, or ready with stalls of random length, style set per phase
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_hold  <= 0;
        end
        else if (rx_mode == 0)
            m_tready <= 1'b1;
        else if (rx_hold > 0)
        begin
            m_tready <= 1'b0;
            rx_hold  <= rx_hold - 1;
        end
        else
        begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                rx_hold <= $urandom_range(1, (rx_mode == 1) ? 3 : 12);
        end
    end

    // one register write, setup then access
    task automatic apb_write(input logic [IDX_BITS-1:0] idx, input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        reg_writes++;
    endtask

    // one input request, with a random gap at the start of each burst unless the style has none
    task automatic send_sample(input int smp, input logic clr, input bit typed,
                               input filt_res_t answer);
        int gap;
        if (burst_left == 0)
        begin
            gap = (tx_mode == 0) ? 0 : $urandom_range(0, (tx_mode == 1) ? 4 : 20);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= smp[SBITS-1:0];
        s_tuser    <= clr;
        row_typed  <= typed;
        row_expect <= answer;
        do
            @(posedge clk);
        while (!s_tready);
        burst_left--;
        samples_sent++;
    endtask

    // stop sending and wait for every outstanding result
    task automatic wait_idle();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        while (samples_checked != samples_sent)
            @(posedge clk);
    endtask

    function automatic int pick_coef(input int style);
        if (style == 0)
            return $urandom_range(0, 131071) - 65536;
        return $urandom_range(0, 1048575) + CMIN;
    endfunction

    function automatic int pick_sample();
        case ($urandom_range(0, 7))
            0:
            begin
                case ($urandom_range(0, 4))
                    0: return SMAX;
                    1: return SMIN;
                    2: return 0;
                    3: return -1;
                    default: return 1;
                endcase
            end
            1: return $urandom_range(0, 255) - 128;
            default: return $urandom_range(0, 65535) + SMIN;
        endcase
    endfunction

    // stimulus
    initial
    begin
        dir_row_t  r;
        filt_res_t answer;
        int        phase;
        int        style;
        int        n;
        int        b0, b1, b2, a1, a2;
        bit        byp;

        // after reset b0 is unity, so samples pass exactly
        dir_rows.push_back('{ROW_SAMPLE, '0, 0,    1'b0, 1'b1, 0,    1'b0});
        dir_rows.push_back('{ROW_SAMPLE, '0, SMAX, 1'b0, 1'b1, SMAX, 1'b0});
        dir_rows.push_back('{ROW_SAMPLE, '0, SMIN, 1'b0, 1'b1, SMIN, 1'b0});
        dir_rows.push_back('{ROW_SAMPLE, '0, -1,   1'b0, 1'b1, -1,   1'b0});
        // b0 = 0.5: halves round up
        dir_rows.push_back('{ROW_CFG,    REG_B0, 32768, 1'b0, 1'b0, 0, 1'b0});
        dir_rows.push_back('{ROW_SAMPLE, '0, 1,    1'b1, 1'b1, 1,    1'b0});
        dir_rows.push_back('{ROW_SAMPLE, '0, -1,   1'b0, 1'b1, 0,    1'b0});
        dir_rows.push_back('{ROW_SAMPLE, '0, 3,    1'b0, 1'b1, 2,    1'b0});
        dir_rows.push_back('{ROW_SAMPLE, '0, -3,   1'b0, 1'b1, -1,   1'b0});
        // largest gain clips both ways
        dir_rows.push_back('{ROW_CFG,    REG_B0, CMAX, 1'b0, 1'b0, 0, 1'b0});
        dir_rows.push_back('{ROW_SAMPLE, '0, SMAX, 1'b1, 1'b1, SMAX, 1'b1});
        dir_rows.push_back('{ROW_SAMPLE, '0, SMIN, 1'b0, 1'b1, SMIN, 1'b1});
        dir_rows.push_back('{ROW_SAMPLE, '0, 1,    1'b0, 1'b1, 8,    1'b0});
        // most negative gain, one clip and one exact landing on the minimum
        dir_rows.push_back('{ROW_CFG,    REG_B0, CMIN, 1'b0, 1'b0, 0, 1'b0});
        dir_rows.push_back('{ROW_SAMPLE, '0, SMIN, 1'b0, 1'b1, SMAX, 1'b1});
        dir_rows.push_back('{ROW_SAMPLE, '0, 4096, 1'b0, 1'b1, SMIN, 1'b0});
        // a low-pass section driven by an impulse
        dir_rows.push_back('{ROW_CFG,    REG_B0, 16384,  1'b0, 1'b0, 0, 1'b0});
        dir_rows.push_back('{ROW_CFG,    REG_B1, 32768,  1'b0, 1'b0, 0, 1'b0});
        dir_rows.push_back('{ROW_CFG,    REG_B2, 16384,  1'b0, 1'b0, 0, 1'b0});
        dir_rows.push_back('{ROW_CFG,    REG_A1, -60000, 1'b0, 1'b0, 0, 1'b0});
        dir_rows.push_back('{ROW_CFG,    REG_A2, 28000,  1'b0, 1'b0, 0, 1'b0});
        dir_rows.push_back('{ROW_SAMPLE, '0, SMAX, 1'b1, 1'b0, 0, 1'b0});
        dir_rows.push_back('{ROW_SAMPLE, '0, 0,    1'b0, 1'b0, 0, 1'b0});
        dir_rows.push_back('{ROW_SAMPLE, '0, 0,    1'b0, 1'b0, 0, 1'b0});
        dir_rows.push_back('{ROW_SAMPLE, '0, SMIN, 1'b0, 1'b0, 0, 1'b0});
        // extreme feedback, partial sums swing hard
        dir_rows.push_back('{ROW_CFG,    REG_B1, CMAX, 1'b0, 1'b0, 0, 1'b0});
        dir_rows.push_back('{ROW_CFG,    REG_B2, CMAX, 1'b0, 1'b0, 0, 1'b0});
        dir_rows.push_back('{ROW_CFG,    REG_A1, CMIN, 1'b0, 1'b0, 0, 1'b0});
        dir_rows.push_back('{ROW_CFG,    REG_A2, CMAX, 1'b0, 1'b0, 0, 1'b0});
        dir_rows.push_back('{ROW_SAMPLE, '0, SMAX, 1'b1, 1'b0, 0, 1'b0});
        dir_rows.push_back('{ROW_SAMPLE, '0, SMIN, 1'b0, 1'b0, 0, 1'b0});
        dir_rows.push_back('{ROW_SAMPLE, '0, SMAX, 1'b0, 1'b0, 0, 1'b0});
        // bypass copies the sample, a clear still empties the sums
        dir_rows.push_back('{ROW_CFG,    REG_BYPASS, 1, 1'b0, 1'b0, 0, 1'b0});
        dir_rows.push_back('{ROW_SAMPLE, '0, -12345, 1'b1, 1'b1, -12345, 1'b0});
        dir_rows.push_back('{ROW_SAMPLE, '0, SMAX,   1'b0, 1'b1, SMAX,   1'b0});
        dir_rows.push_back('{ROW_CFG,    REG_SPARE6, 1,  1'b0, 1'b0, 0, 1'b0});
        dir_rows.push_back('{ROW_CFG,    REG_SPARE7, -1, 1'b0, 1'b0, 0, 1'b0});
        dir_rows.push_back('{ROW_CFG,    REG_BYPASS, 0,  1'b0, 1'b0, 0, 1'b0});
        dir_rows.push_back('{ROW_SAMPLE, '0, 1000, 1'b0, 1'b0, 0, 1'b0});

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        foreach (dir_rows[i])
        begin
            r = dir_rows[i];
            if (r.kind == ROW_CFG)
            begin
                wait_idle();
                apb_write(r.idx, r.value);
            end
            else
            begin
                answer.y   = r.exp_y[SBITS-1:0];
                answer.sat = r.exp_sat;
                send_sample(r.value, r.clr, r.typed, answer);
            end
        end

        // random phases, each with its own coefficients and idle styles
        for (phase = 0; phase < PHASES; phase++)
        begin
            wait_idle();
            rx_mode <= phase % 3;
            tx_mode = (phase + 1) % 3;
            style   = $urandom_range(0, 1);
            if (phase == 0)
            begin
                b0 = CMAX; b1 = CMAX; b2 = CMAX; a1 = CMAX; a2 = CMAX;
            end
            else if (phase == 1)
            begin
                b0 = CMIN; b1 = CMIN; b2 = CMIN; a1 = CMIN; a2 = CMIN;
            end
            else
            begin
                b0 = pick_coef(style);
                b1 = pick_coef(style);
                b2 = pick_coef(style);
                a1 = pick_coef(style);
                a2 = pick_coef(style);
            end
            byp = (phase == 5) || (phase > 1 && $urandom_range(0, 5) == 0);
            apb_write(REG_B0, b0);
            apb_write(REG_B1, b1);
            apb_write(REG_B2, b2);
            apb_write(REG_A1, a1);
            apb_write(REG_A2, a2);
            apb_write(REG_BYPASS, byp);
            if ($urandom_range(0, 2) == 0)
                apb_write($urandom_range(0, 1) ? REG_SPARE6 : REG_SPARE7, $urandom());
            n = $urandom_range(70, 90);
            repeat (n)
                send_sample(pick_sample(), $urandom_range(0, 15) == 0, 1'b0, '0);
        end

        wait_idle();
        repeat (20) @(posedge clk);
        $display("%0d samples filtered over %0d register writes: %0d bypassed, %0d clipped",
                 samples_sent, reg_writes, bypassed_cnt, clipped_cnt);
        if (mismatch_cnt == 0 && expected_samples.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // watchdog
    initial
    begin
        #400000;
        $display("Mismatches found");
        $finish;
    end

endmodule
